>>> hw/rtl/scpe_pkg.sv
// ----------------------------------------------------------------------------
// scpe_pkg
// Shared types and constants for the 2D sine/cosine position encoder.
// ----------------------------------------------------------------------------
package scpe_pkg;

    localparam logic [31:0] FREQ_ONE       = 32'hFFFF_FFFF;
    localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
    localparam logic [31:0] CORDIC_GAIN    = 32'd652032874;

    localparam logic [1:0] CFG_GRID_COLS  = 2'd0;
    localparam logic [1:0] CFG_EMBED_DIM  = 2'd1;
    localparam logic [1:0] CFG_FREQ_RATIO = 2'd2;

    // Work word handed from the front end to the arithmetic back end.
    typedef struct packed {
        logic [31:0] value;
        logic        enc;
        logic        want_sin;
        logic [31:0] turn;
    } job_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] k);
        logic [31:0] r;
        begin
            case (k)
                5'd0: r = 32'd536870912;   5'd1: r = 32'd316933406;
                5'd2: r = 32'd167458907;   5'd3: r = 32'd85004756;
                5'd4: r = 32'd42667331;    5'd5: r = 32'd21354465;
                5'd6: r = 32'd10679838;    5'd7: r = 32'd5340245;
                5'd8: r = 32'd2670163;     5'd9: r = 32'd1335087;
                5'd10: r = 32'd667544;     5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;     5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;      5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;      5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;       5'd19: r = 32'd1304;
                5'd20: r = 32'd652;        5'd21: r = 32'd326;
                5'd22: r = 32'd163;        5'd23: r = 32'd81;
                5'd24: r = 32'd41;         5'd25: r = 32'd20;
                5'd26: r = 32'd10;         5'd27: r = 32'd5;
                5'd28: r = 32'd3;          5'd29: r = 32'd1;
                5'd30: r = 32'd1;          default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

>>> hw/rtl/sincos_2d_position_encoder.sv
// ----------------------------------------------------------------------------
// sincos_2d_position_encoder
// Adds a 2D sine/cosine position code to a stream of Q16.16 embedding words.
// An accepted word passes through the front end (S_MUL1, S_MUL2, S_OUT), the
// two-entry queue and the back end (S_ROT for encoded words only, S_SUM, S_OUT).
// Neither end takes a new word before it has handed on the last one; the shared
// CORDIC rotator limits the rate of encoded words, the front end that of passed words.
// Reset: asynchronous, active low; counters clear, frequency is one,
// registers take grid columns 16, embed_dim 768, freq_ratio 3901977000.
// ----------------------------------------------------------------------------
module sincos_2d_position_encoder #(
    parameter int MAX_DIM      = 4096,
    parameter int MAX_GRID     = 1024,
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] embed_value,
    input  logic        image_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] encoded_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    logic [10:0] grid_cols_reg;
    logic [12:0] embed_dim_reg;
    logic [31:0] freq_ratio_reg;

    scpe_pkg::job_t fj, bj;
    logic fv, fr, bv, br;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg  <= 11'd16;
            embed_dim_reg  <= 13'd768;
            freq_ratio_reg <= 32'd3901977000;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                scpe_pkg::CFG_GRID_COLS:  grid_cols_reg  <= cfg_data[10:0];
                scpe_pkg::CFG_EMBED_DIM:  embed_dim_reg  <= cfg_data[12:0];
                scpe_pkg::CFG_FREQ_RATIO: freq_ratio_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    scpe_front #(.MAX_DIM(MAX_DIM), .MAX_GRID(MAX_GRID)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .embed_value(embed_value), .image_start(image_start),
        .grid_cols(grid_cols_reg), .embed_dim(embed_dim_reg),
        .freq_ratio(freq_ratio_reg),
        .job_valid(fv), .job_ready(fr), .job(fj)
    );

    scpe_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fv), .wr_ready(fr), .wr_data(fj),
        .rd_valid(bv), .rd_ready(br), .rd_data(bj)
    );

    scpe_back #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(bv), .job_ready(br), .job(bj),
        .out_valid(out_valid), .out_ready(out_ready),
        .encoded_value(encoded_value)
    );
endmodule

>>> hw/rtl/scpe_front.sv
// ----------------------------------------------------------------------------
// scpe_front
// Position counters, block classification, frequency recurrence and angle.
// ----------------------------------------------------------------------------
module scpe_front #(
    parameter int MAX_DIM  = 4096,
    parameter int MAX_GRID = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [31:0]          embed_value,
    input  logic                 image_start,
    input  logic [10:0]          grid_cols,
    input  logic [12:0]          embed_dim,
    input  logic [31:0]          freq_ratio,
    output logic                 job_valid,
    input  logic                 job_ready,
    output scpe_pkg::job_t       job
);
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int GW = $clog2(MAX_GRID + 1);

    typedef enum logic [1:0] {S_IDLE, S_MUL1, S_MUL2, S_OUT} st_t;

    st_t          st_reg;
    logic [DW-1:0] elem_reg;
    logic [GW-1:0] col_reg, row_reg;
    logic [31:0]  freq_reg, f_reg, val_reg;
    logic         enc_reg, sin_reg;
    logic [GW-1:0] pos_reg;
    logic [63:0]  a_reg;
    logic [31:0]  turn_reg;

    logic [DW-1:0] dim, q, h, e;
    logic [GW-1:0] gw, col0, row0;
    logic [DW-1:0] off;
    logic          enc, wsin, use_row;

    assign in_ready  = (st_reg == S_IDLE);
    assign job_valid = (st_reg == S_OUT);
    assign job       = '{value: val_reg, enc: enc_reg, want_sin: sin_reg, turn: turn_reg};

    always_comb
    begin
        if (embed_dim == 13'd0)
            dim = DW'(1);
        else if (32'(embed_dim) > MAX_DIM)
            dim = DW'(MAX_DIM);
        else
            dim = DW'(embed_dim);
        if (grid_cols == 11'd0)
            gw = GW'(1);
        else if (32'(grid_cols) > MAX_GRID)
            gw = GW'(MAX_GRID);
        else
            gw = GW'(grid_cols);
        q = dim >> 2;
        h = dim >> 1;
        e    = image_start ? '0 : elem_reg;
        col0 = image_start ? '0 : col_reg;
        row0 = image_start ? '0 : row_reg;
        enc = 1'b0; wsin = 1'b0; off = '0; use_row = 1'b1;
        if (q != '0 && e < dim)
        begin
            if (e < q)
            begin
                enc = 1'b1; wsin = 1'b1; off = e;
            end
            else if (e < (q << 1))
            begin
                enc = 1'b1; off = e - q;
            end
            else if (e >= h && e < h + q)
            begin
                enc = 1'b1; wsin = 1'b1; off = e - h; use_row = 1'b0;
            end
            else if (e >= h + q && e < h + (q << 1))
            begin
                enc = 1'b1; off = e - h - q; use_row = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            elem_reg <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
            freq_reg <= scpe_pkg::FREQ_ONE;
        end
        else
        begin
            case (st_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        val_reg <= embed_value;
                        enc_reg <= enc;
                        sin_reg <= wsin;
                        pos_reg <= use_row ? row0 : col0;
                        f_reg   <= (off == '0) ? scpe_pkg::FREQ_ONE : freq_reg;
                        if (32'(e) + 1 >= 32'(dim))
                        begin
                            elem_reg <= '0;
                            if (32'(col0) + 1 >= 32'(gw))
                            begin
                                col_reg <= '0;
                                row_reg <= (32'(row0) + 1 < MAX_GRID) ? row0 + GW'(1) : row0;
                            end
                            else
                            begin
                                col_reg <= col0 + GW'(1);
                                row_reg <= row0;
                            end
                        end
                        else
                        begin
                            elem_reg <= e + DW'(1);
                            col_reg  <= col0;
                            row_reg  <= row0;
                        end
                        st_reg <= S_MUL1;
                    end
                end
                S_MUL1:
                begin
                    // position times frequency; advance the recurrence for an encoded word
                    a_reg <= 64'(pos_reg) * 64'(f_reg);
                    if (enc_reg)
                        freq_reg <= 32'((64'(f_reg) * 64'(freq_ratio)) >> 32);
                    st_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    turn_reg <= 32'(64'(a_reg[63:32]) * 64'(scpe_pkg::INV_TWO_PI_Q32))
                              + 32'((64'(a_reg[31:0]) * 64'(scpe_pkg::INV_TWO_PI_Q32)) >> 32);
                    st_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (job_ready)
                        st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule

>>> hw/rtl/scpe_queue.sv
// ----------------------------------------------------------------------------
// scpe_queue
// Two-entry word queue between the front end and the back end.
// ----------------------------------------------------------------------------
module scpe_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  scpe_pkg::job_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output scpe_pkg::job_t rd_data
);
    scpe_pkg::job_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule

>>> hw/rtl/scpe_back.sv
// ----------------------------------------------------------------------------
// scpe_back
// Iterative CORDIC rotation, rounding and saturating add.
// ----------------------------------------------------------------------------
module scpe_back #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 24
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           job_ready,
    input  scpe_pkg::job_t job,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [31:0]    encoded_value
);
    localparam int STEPS = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;

    typedef enum logic [1:0] {S_IDLE, S_ROT, S_SUM, S_OUT} st_t;

    st_t          st_reg;
    logic [4:0]   k_reg;
    logic signed [33:0] x_reg, y_reg, z_reg;
    logic         flip_reg, sin_reg, enc_reg;
    logic signed [32:0] val_reg;
    logic [31:0]  out_reg;

    logic [31:0]  t_red;
    logic         flip;
    logic signed [33:0] xs, ys, at, t30, term;
    logic signed [34:0] sum;

    assign job_ready     = (st_reg == S_IDLE);
    assign out_valid     = (st_reg == S_OUT);
    assign encoded_value = out_reg;

    always_comb
    begin
        flip  = (job.turn[31:30] == 2'b01) || (job.turn[31:30] == 2'b10);
        t_red = flip ? job.turn - 32'h8000_0000 : job.turn;
        xs = x_reg >>> k_reg;
        ys = y_reg >>> k_reg;
        at = 34'(scpe_pkg::atan_turn(k_reg));
        t30 = sin_reg ? y_reg : x_reg;
        if (flip_reg)
            t30 = -t30;
        term = (t30 + (34'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        sum = 35'(val_reg) + 35'(term);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg <= S_IDLE;
        end else begin
            case (st_reg)
                S_IDLE:
                begin
                    if (job_valid) begin
                        x_reg    <= 34'(scpe_pkg::CORDIC_GAIN);
                        y_reg    <= '0;
                        z_reg    <= 34'(signed'(t_red));
                        flip_reg <= flip;
                        sin_reg  <= job.want_sin;
                        enc_reg  <= job.enc;
                        val_reg  <= 33'(signed'(job.value));
                        k_reg    <= '0;
                        st_reg   <= job.enc ? S_ROT : S_SUM;
                    end
                end
                S_ROT:
                begin
                    // one micro-rotation per cycle
                    if (!z_reg[33]) begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - at;
                    end else begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + at;
                    end
                    if (32'(k_reg) == STEPS - 1)
                        st_reg <= S_SUM;
                    k_reg <= k_reg + 5'd1;
                end
                S_SUM:
                begin
                    if (!enc_reg)
                        out_reg <= val_reg[31:0];
                    else if (sum > 35'sd2147483647)
                        out_reg <= 32'h7FFF_FFFF;
                    else if (sum < -35'sd2147483648)
                        out_reg <= 32'h8000_0000;
                    else
                        out_reg <= sum[31:0];
                    st_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                        st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
